>>> src/bbge_pkg.sv
// shared types and constants of the brian's brain generation engine
// no dependencies; every other file refers to this package by scoped names
`timescale 1ns / 1ps
`default_nettype none

package bbge_pkg;

    // field widths of the channels
    localparam int FUNC_W    = 2;
    localparam int POS_W     = 6;
    localparam int STATE_W   = 2;
    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 1;

    // default grid capacity
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_GEN   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

    // cell states
    localparam logic [STATE_W-1:0] CELL_ON    = 2'd0;
    localparam logic [STATE_W-1:0] CELL_DYING = 2'd1;
    localparam logic [STATE_W-1:0] CELL_OFF   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // controls for the three-row window held in the column cells
    typedef struct packed {
        logic load_up;
        logic load_mid;
        logic load_low;
        logic load_save;
        logic shift;
        logic low_from_save;
    } bbge_win_ctl_t;

endpackage

`default_nettype wire

>>> src/bbge_if.sv
// channel interfaces: command, response and configuration write
// depends on bbge_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bbge_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [bbge_pkg::FUNC_W-1:0]   func;
    logic [bbge_pkg::POS_W-1:0]    row;
    logic [bbge_pkg::POS_W-1:0]    col;
    logic [bbge_pkg::STATE_W-1:0]  cell_value;

    modport source (output valid, func, row, col, cell_value, input ready);
    modport sink (input valid, func, row, col, cell_value, output ready);
endinterface

interface bbge_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bbge_pkg::STATE_W-1:0]  cell_state;
    logic [bbge_pkg::FUNC_W-1:0]   op_done;

    modport source (output valid, cell_state, op_done, input ready);
    modport sink (input valid, cell_state, op_done, output ready);
endinterface

interface bbge_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bbge_pkg::CFG_IDX_W-1:0]  index;
    logic [bbge_pkg::SIZE_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/bbge_cell.sv
// one column cell: holds its column of the upper, middle and lower rows
// and computes the next state of the middle cell; depends on bbge_pkg
`timescale 1ns / 1ps
`default_nettype none

module bbge_cell
(
    input  wire                                clk,
    input  bbge_pkg::bbge_win_ctl_t            ctl,
    input  wire [bbge_pkg::STATE_W-1:0]        rd_cell,
    input  wire                                active,
    input  wire [2:0]                          left_on,
    input  wire [2:0]                          right_on,
    output logic [2:0]                         on_bits,
    output logic [bbge_pkg::STATE_W-1:0]       nxt
);

    logic [bbge_pkg::STATE_W-1:0] up_reg;
    logic [bbge_pkg::STATE_W-1:0] mid_reg;
    logic [bbge_pkg::STATE_W-1:0] low_reg;
    logic [bbge_pkg::STATE_W-1:0] save_reg;
    logic [3:0]                   cnt;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            up_reg  <= mid_reg;
            mid_reg <= low_reg;
            low_reg <= ctl.low_from_save ? save_reg : rd_cell;
        end
        else
        begin
            if (ctl.load_up)
                up_reg <= rd_cell;
            if (ctl.load_mid)
                mid_reg <= rd_cell;
            if (ctl.load_low)
                low_reg <= rd_cell;
        end
        // old first row, needed again as lower neighbor of the last row
        if (ctl.load_save)
            save_reg <= rd_cell;
    end

    assign on_bits = {up_reg == bbge_pkg::CELL_ON,
                      mid_reg == bbge_pkg::CELL_ON,
                      low_reg == bbge_pkg::CELL_ON};

    always_comb
    begin
        cnt = {3'b0, left_on[2]} + {3'b0, left_on[1]} + {3'b0, left_on[0]}
            + {3'b0, right_on[2]} + {3'b0, right_on[1]} + {3'b0, right_on[0]}
            + {3'b0, on_bits[2]} + {3'b0, on_bits[0]};
    end

    always_comb
    begin
        if (!active)
            nxt = mid_reg;
        else if (mid_reg == bbge_pkg::CELL_ON)
            nxt = bbge_pkg::CELL_DYING;
        else if (mid_reg == bbge_pkg::CELL_DYING)
            nxt = bbge_pkg::CELL_OFF;
        else
            nxt = (cnt == 4'd2) ? bbge_pkg::CELL_ON : bbge_pkg::CELL_OFF;
    end

endmodule

`default_nettype wire

>>> src/brians_brain_generation_engine_core.sv
// Brian's brain grid engine. The grid is kept in a row-wide memory, one row of
// MAX_COLS two-bit cells per word, next to a chain of MAX_COLS column cells that
// hold a three-row window and compute a whole new row at once. After reset a
// clearing pass writes every row to off; no command is taken during it. A
// write or read goes through the cell and finish states to its response; a
// no-op is taken in idle and gives no response. A generation loads the window,
// then writes each new row and shifts the window in separate states. The
// memory has one row port for writes and one for reads. A result may wait in
// the output register while the next command is accepted.
// depends on bbge_pkg, bbge_if and bbge_cell
`timescale 1ns / 1ps
`default_nettype none

module brians_brain_generation_engine_core
#(
    parameter int MAX_ROWS = bbge_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = bbge_pkg::DEF_MAX_COLS
)
(
    input  wire        clk,
    input  wire        rst_n,
    bbge_cmd_if.sink   cmd,
    bbge_rsp_if.source rsp,
    bbge_cfg_if.sink   cfg
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RUW = $clog2(MAX_ROWS + 1);
    localparam int CUW = $clog2(MAX_COLS + 1);
    localparam int SW  = bbge_pkg::STATE_W;
    localparam int FW  = bbge_pkg::FUNC_W;

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_CELL   = 4'd2;
    localparam logic [3:0] ST_PRE_A  = 4'd3;
    localparam logic [3:0] ST_PRE_B  = 4'd4;
    localparam logic [3:0] ST_PRE_C  = 4'd5;
    localparam logic [3:0] ST_PRE_D  = 4'd6;
    localparam logic [3:0] ST_GEN_WR = 4'd7;
    localparam logic [3:0] ST_GEN_SH = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    typedef logic [MAX_COLS-1:0][SW-1:0] row_t;

    // configuration
    logic [bbge_pkg::SIZE_W-1:0] width_reg;
    logic [bbge_pkg::SIZE_W-1:0] height_reg;
    logic [31:0]                 w32;
    logic [31:0]                 h32;
    logic [CUW-1:0]              cols_use;
    logic [RUW-1:0]              rows_use;
    logic [CUW-1:0]              cols_m1_full;
    logic [CW-1:0]               cols_m1;
    logic [RUW-1:0]              rows_m1_full;
    logic [RW-1:0]               rows_m1;

    // control
    logic [3:0]    state_reg;
    logic [3:0]    state_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [RUW:0]  row_p2;
    logic          near_ok;

    // captured command
    logic [FW-1:0] func_reg;
    logic [RW-1:0] addr_reg;
    logic [CW-1:0] col_idx_reg;
    logic [SW-1:0] val_reg;
    logic          inside_reg;
    logic [SW-1:0] res_reg;
    logic [31:0]   cmd_row32;
    logic [31:0]   cmd_col32;
    logic          cmd_inside;
    logic          cmd_acc;

    // output register
    logic          out_valid_reg;
    logic [SW-1:0] out_state_reg;
    logic [FW-1:0] out_func_reg;
    logic          out_load;

    // memory
    row_t          mem [MAX_ROWS];
    row_t          rdata_reg;
    row_t          wdata;
    row_t          merged;
    row_t          new_row;
    logic          mem_we;
    logic          mem_re;
    logic [RW-1:0] waddr;
    logic [RW-1:0] raddr;

    // column chain
    bbge_pkg::bbge_win_ctl_t ctl;
    logic [2:0]              on_bits  [MAX_COLS];
    logic [2:0]              left_on  [MAX_COLS];
    logic [2:0]              right_on [MAX_COLS];
    logic [MAX_COLS-1:0]     active;
    logic [MAX_COLS-1:0]     is_last;
    logic [2:0]              wrap_on;

    // size in use, clamped to the capacity
    assign w32 = 32'(width_reg);
    assign h32 = 32'(height_reg);
    assign cols_use = (w32 == 32'd0) ? CUW'(1) :
                      (w32 > 32'(MAX_COLS)) ? CUW'(MAX_COLS) : CUW'(w32);
    assign rows_use = (h32 == 32'd0) ? RUW'(1) :
                      (h32 > 32'(MAX_ROWS)) ? RUW'(MAX_ROWS) : RUW'(h32);
    assign cols_m1_full = cols_use - CUW'(1);
    assign cols_m1      = cols_m1_full[CW-1:0];
    assign rows_m1_full = rows_use - RUW'(1);
    assign rows_m1      = rows_m1_full[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bbge_pkg::SIZE_RESET;
            height_reg <= bbge_pkg::SIZE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                bbge_pkg::CFG_GRID_WIDTH:  width_reg  <= cfg.data;
                bbge_pkg::CFG_GRID_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;

    // command decode
    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_acc    = cmd.valid && cmd.ready;
    assign cmd_row32  = 32'(cmd.row);
    assign cmd_col32  = 32'(cmd.col);
    assign cmd_inside = (cmd_row32 < 32'(rows_use)) && (cmd_col32 < 32'(cols_use));

    assign row_p2  = (RUW+1)'(row_reg) + (RUW+1)'(2);
    assign near_ok = row_p2 < (RUW+1)'(rows_use);

    always_comb
    begin
        merged = rdata_reg;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            if (col_idx_reg == CW'(i))
                merged[i] = val_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        waddr      = row_reg;
        raddr      = row_reg;
        wdata      = new_row;
        ctl        = '0;
        case (state_reg)
            ST_CLR:
            begin
                mem_we = 1'b1;
                wdata  = {MAX_COLS{bbge_pkg::CELL_OFF}};
                if (row_reg == RW'(MAX_ROWS - 1))
                begin
                    row_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                    row_next = row_reg + RW'(1);
            end
            ST_IDLE:
            begin
                mem_re = cmd_acc;
                raddr  = cmd_row32[RW-1:0];
                if (cmd_acc)
                begin
                    case (cmd.func)
                        bbge_pkg::FUNC_WRITE, bbge_pkg::FUNC_READ: state_next = ST_CELL;
                        bbge_pkg::FUNC_GEN: state_next = ST_PRE_A;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CELL:
            begin
                mem_we     = (func_reg == bbge_pkg::FUNC_WRITE) && inside_reg;
                waddr      = addr_reg;
                wdata      = merged;
                state_next = ST_FIN;
            end
            ST_PRE_A:
            begin
                mem_re     = 1'b1;
                raddr      = rows_m1;
                state_next = ST_PRE_B;
            end
            ST_PRE_B:
            begin
                ctl.load_up = 1'b1;
                mem_re      = 1'b1;
                raddr       = '0;
                state_next  = ST_PRE_C;
            end
            ST_PRE_C:
            begin
                ctl.load_mid  = 1'b1;
                ctl.load_save = 1'b1;
                mem_re        = 1'b1;
                raddr         = (rows_use == RUW'(1)) ? RW'(0) : RW'(1);
                state_next    = ST_PRE_D;
            end
            ST_PRE_D:
            begin
                ctl.load_low = 1'b1;
                row_next     = '0;
                state_next   = ST_GEN_WR;
            end
            ST_GEN_WR:
            begin
                mem_we = 1'b1;
                mem_re = near_ok;
                raddr  = row_p2[RW-1:0];
                if (row_reg == rows_m1)
                    state_next = ST_FIN;
                else
                    state_next = ST_GEN_SH;
            end
            ST_GEN_SH:
            begin
                // past the last row the lower neighbor is the saved old first row
                ctl.shift         = 1'b1;
                ctl.low_from_save = !near_ok;
                row_next          = row_reg + RW'(1);
                state_next        = ST_GEN_WR;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            func_reg    <= cmd.func;
            addr_reg    <= cmd_row32[RW-1:0];
            col_idx_reg <= cmd_col32[CW-1:0];
            val_reg     <= (cmd.cell_value == 2'd3) ? bbge_pkg::CELL_OFF : cmd.cell_value;
            inside_reg  <= cmd_inside;
            res_reg     <= '0;
        end
        else if (state_reg == ST_CELL && func_reg == bbge_pkg::FUNC_READ)
            res_reg <= inside_reg ? rdata_reg[col_idx_reg] : bbge_pkg::CELL_OFF;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        if (mem_re)
            rdata_reg <= mem[raddr];
    end

    // output register
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_state_reg <= res_reg;
            out_func_reg  <= func_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.cell_state = out_state_reg;
    assign rsp.op_done    = out_func_reg;

    // column chain with wrap at the column count in use
    assign wrap_on = on_bits[cols_m1];

    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_col
        assign active[c]  = CUW'(c) < cols_use;
        assign is_last[c] = CUW'(c) == cols_m1_full;

        if (c == 0)
        begin : g_left_wrap
            assign left_on[c] = wrap_on;
        end
        else
        begin : g_left
            assign left_on[c] = on_bits[c-1];
        end

        if (c == MAX_COLS - 1)
        begin : g_right_wrap
            assign right_on[c] = on_bits[0];
        end
        else
        begin : g_right
            assign right_on[c] = is_last[c] ? on_bits[0] : on_bits[c+1];
        end

        bbge_cell u_cell
        (
            .clk      (clk),
            .ctl      (ctl),
            .rd_cell  (rdata_reg[c]),
            .active   (active[c]),
            .left_on  (left_on[c]),
            .right_on (right_on[c]),
            .on_bits  (on_bits[c]),
            .nxt      (new_row[c])
        );
    end

endmodule

`default_nettype wire

>>> src/bbge_checker.sv
// port-level checks of the engine and the bind that attaches them
// depends on bbge_pkg and brians_brain_generation_engine_core
`timescale 1ns / 1ps
`default_nettype none

module bbge_checker
(
    input wire                           clk,
    input wire                           rst_n,
    input wire                           cmd_valid,
    input wire                           cmd_ready,
    input wire [bbge_pkg::FUNC_W-1:0]    cmd_func,
    input wire                           rsp_valid,
    input wire                           rsp_ready,
    input wire [bbge_pkg::STATE_W-1:0]   rsp_cell_state,
    input wire [bbge_pkg::FUNC_W-1:0]    rsp_op_done
);

    logic [1:0] pend_reg;
    logic       inc;
    logic       dec;

    assign inc = cmd_valid && cmd_ready && (cmd_func != bbge_pkg::FUNC_NOP);
    assign dec = rsp_valid && rsp_ready;

    // transactions accepted that still owe a response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else if (inc && !dec)
            pend_reg <= pend_reg + 2'd1;
        else if (dec && !inc)
            pend_reg <= pend_reg - 2'd1;
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_cell_state) && $stable(rsp_op_done))
        else $error("response changed while stalled");

    a_rsp_owed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without an accepted command");

    a_state_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_op_done != bbge_pkg::FUNC_READ |-> rsp_cell_state == '0)
        else $error("cell state not zero for write or generation");

    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_op_done != bbge_pkg::FUNC_NOP && rsp_cell_state != 2'd3)
        else $error("illegal code on response");

endmodule

bind brians_brain_generation_engine_core bbge_checker u_bbge_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_func       (cmd.func),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_cell_state (rsp.cell_state),
    .rsp_op_done    (rsp.op_done)
);

`default_nettype wire
